@@ rtl/sprpd_pkg.sv @@
// Shared types, constants and the sequencer program of the setpoint ramp drive.
package sprpd_pkg;

    // Field widths.
    localparam int POS_W   = 24;
    localparam int STEP_W  = 23;
    localparam int DELAY_W = 16;
    localparam int COEF_W  = 32;
    localparam int VOLT_W  = 21;
    localparam int CFG_IDX_W = 3;
    localparam int PC_W    = 3;

    // Horner accumulator and product widths (LSB 2^-20 and 2^-42).
    localparam int ACC_W  = 37;
    localparam int PROD_W = 61;
    localparam int HALF_W = 18;

    // Saturation limit of the drive voltage, +/-10 V at LSB 2^-16.
    localparam int VOLT_MAX = 655360;

    // Register reset values.
    localparam logic [STEP_W-1:0]         STEP_SIZE_RST  = 23'd4194;
    localparam logic [DELAY_W-1:0]        STEP_DELAY_RST = 16'd10;
    localparam logic signed [COEF_W-1:0]  COEF0_RST = 32'sd27412;
    localparam logic signed [COEF_W-1:0]  COEF1_RST = -32'sd36713791;
    localparam logic signed [COEF_W-1:0]  COEF2_RST = 32'sd2006031;
    localparam logic signed [COEF_W-1:0]  COEF3_RST = 32'sd4851866;
    localparam logic signed [COEF_W-1:0]  COEF4_RST = -32'sd18884854;

    // Request opcodes.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_SIZE  = 3'd0,
        CFG_STEP_DELAY = 3'd1,
        CFG_COEF_ZERO  = 3'd2,
        CFG_COEF_ONE   = 3'd3,
        CFG_COEF_TWO   = 3'd4,
        CFG_COEF_THREE = 3'd5,
        CFG_COEF_FOUR  = 3'd6
    } cfg_idx_t;

    // Request and result payloads.
    typedef struct packed {
        logic                    op;
        logic signed [POS_W-1:0] target_value;
    } req_t;

    typedef struct packed {
        logic signed [VOLT_W-1:0] drive_volts;
        logic signed [POS_W-1:0]  position_now;
        logic                     final_step;
    } res_t;

    // Micro-operations of the sequencer.
    typedef enum logic [2:0] {
        UOP_GAP,
        UOP_MOVE,
        UOP_MULH,
        UOP_MULL,
        UOP_ACC,
        UOP_FIN
    } uop_t;

    // One control word: operation, conditional jump and its target.
    typedef struct packed {
        uop_t            uop;
        logic            jump;
        logic [PC_W-1:0] target;
    } ucode_t;

    // Strobes from the sequencer to the Horner datapath.
    typedef struct packed {
        logic load;
        logic mul_hi;
        logic mul_lo;
        logic add_coef;
    } dp_ctl_t;

    localparam logic [PC_W-1:0] PC_START = 3'd0;
    localparam logic [PC_W-1:0] PC_MULH  = 3'd2;

    // Sequencer program: form the gap, move, then four Horner stages.
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        begin
            w = '{uop: UOP_FIN, jump: 1'b0, target: PC_START};
            unique case (pc)
                3'd0:    w = '{uop: UOP_GAP,  jump: 1'b0, target: PC_START};
                3'd1:    w = '{uop: UOP_MOVE, jump: 1'b0, target: PC_START};
                3'd2:    w = '{uop: UOP_MULH, jump: 1'b0, target: PC_START};
                3'd3:    w = '{uop: UOP_MULL, jump: 1'b0, target: PC_START};
                3'd4:    w = '{uop: UOP_ACC,  jump: 1'b1, target: PC_MULH};
                default: w = '{uop: UOP_FIN,  jump: 1'b0, target: PC_START};
            endcase
            return w;
        end
    endfunction

endpackage

@@ rtl/sprpd_horner.sv @@
// Fixed-point Horner datapath with a split multiplier and output rounding.
module sprpd_horner (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  sprpd_pkg::dp_ctl_t                        ctl,
    input  logic signed [sprpd_pkg::POS_W-1:0]        x,
    input  logic signed [sprpd_pkg::COEF_W-1:0]       coef,
    output logic signed [sprpd_pkg::VOLT_W-1:0]       volts
);

    logic signed [sprpd_pkg::ACC_W-1:0]  acc_reg;
    logic signed [sprpd_pkg::ACC_W-1:0]  acc_next;
    logic signed [sprpd_pkg::PROD_W-1:0] prod_reg;
    logic signed [sprpd_pkg::PROD_W-1:0] prod_next;

    logic signed [sprpd_pkg::ACC_W-sprpd_pkg::HALF_W-1:0] acc_hi;
    logic signed [sprpd_pkg::HALF_W:0]                     acc_lo;
    logic signed [sprpd_pkg::ACC_W+sprpd_pkg::POS_W-sprpd_pkg::HALF_W-1:0] prod_hi;
    logic signed [sprpd_pkg::HALF_W+sprpd_pkg::POS_W:0]                     prod_lo;

    logic signed [sprpd_pkg::ACC_W:0]   rnd;
    logic signed [sprpd_pkg::ACC_W-4:0] shifted;

    // Split the accumulator into a signed upper and an unsigned lower half.
    assign acc_hi  = acc_reg[sprpd_pkg::ACC_W-1:sprpd_pkg::HALF_W];
    assign acc_lo  = {1'b0, acc_reg[sprpd_pkg::HALF_W-1:0]};
    assign prod_hi = acc_hi * x;
    assign prod_lo = acc_lo * x;

    // Upper partial product first, carrying the rounding half (2^21 = 8 << 18),
    // then the lower partial product, then the scaled coefficient add.
    always_comb
    begin
        acc_next  = acc_reg;
        prod_next = prod_reg;
        if (ctl.load)
        begin
            acc_next = sprpd_pkg::ACC_W'(coef);
        end
        if (ctl.mul_hi)
        begin
            prod_next = sprpd_pkg::PROD_W'(prod_hi) + sprpd_pkg::PROD_W'(8);
        end
        if (ctl.mul_lo)
        begin
            prod_next = (prod_reg <<< sprpd_pkg::HALF_W) + sprpd_pkg::PROD_W'(prod_lo);
        end
        if (ctl.add_coef)
        begin
            acc_next = sprpd_pkg::ACC_W'(prod_reg >>> 22) + sprpd_pkg::ACC_W'(coef);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            prod_reg <= '0;
        end
        else
        begin
            acc_reg  <= acc_next;
            prod_reg <= prod_next;
        end
    end

    // Round half up to LSB 2^-16 and saturate to +/-10 V.
    assign rnd     = sprpd_pkg::ACC_W'(acc_reg) + (sprpd_pkg::ACC_W+1)'(8);
    assign shifted = (sprpd_pkg::ACC_W-3)'(rnd >>> 4);

    always_comb
    begin
        if (shifted > (sprpd_pkg::ACC_W-3)'(sprpd_pkg::VOLT_MAX))
        begin
            volts = sprpd_pkg::VOLT_W'(sprpd_pkg::VOLT_MAX);
        end
        else if (shifted < -(sprpd_pkg::ACC_W-3)'(sprpd_pkg::VOLT_MAX))
        begin
            volts = -sprpd_pkg::VOLT_W'(sprpd_pkg::VOLT_MAX);
        end
        else
        begin
            volts = sprpd_pkg::VOLT_W'(shifted);
        end
    end

endmodule

@@ rtl/setpoint_ramp_poly_drive.sv @@
// Top level: slew-rate limited setpoint ramp with a quartic drive calibration.
//
// Requests arrive on req_valid/req_stall/req_data. A request with op LOAD sets a
// new target and takes one ramp step at once; a request with op TICK counts
// down the step delay and takes a step when the delay has run out. Each step
// produces one result on res_valid/res_stall/res_data: the calibrated drive
// voltage, the new position and a flag that marks the last step of a ramp.
// A request that causes no step is absorbed in its acceptance cycle.
// A step runs a small microcoded sequencer: gap, move, then for each of four
// polynomial coefficients an upper partial product, a lower partial product
// and a coefficient add, then output. No new request is taken until the step
// has handed its result over; req_stall is high while the sequence runs.
// The result sits in an output register, so a new request is accepted while a
// result waits. If res_stall holds a result, the next step waits in its final
// cycle until the register frees. Configuration writes on cfg_valid/cfg_ready
// are always ready. The user must make them only while the block is idle; the
// block itself does not enforce this.
// Reset restores the default step size, delay and coefficients, places the
// position and target at zero and leaves the ramp idle.
module setpoint_ramp_poly_drive (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_stall,
    input  sprpd_pkg::req_t                       req_data,
    output logic                                  res_valid,
    input  logic                                  res_stall,
    output sprpd_pkg::res_t                       res_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sprpd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sprpd_pkg::COEF_W-1:0]          cfg_data
);

    // Configuration registers.
    logic [sprpd_pkg::STEP_W-1:0]        step_size_reg;
    logic [sprpd_pkg::DELAY_W-1:0]       step_delay_reg;
    logic signed [sprpd_pkg::COEF_W-1:0] coef_reg [0:4];

    // Ramp state.
    logic signed [sprpd_pkg::POS_W-1:0]  position_reg, position_next;
    logic signed [sprpd_pkg::POS_W-1:0]  goal_reg, goal_next;
    logic                                ramping_reg, ramping_next;
    logic [sprpd_pkg::DELAY_W-1:0]       wait_reg, wait_next;

    // Sequencer state.
    logic                                busy_reg, busy_next;
    logic [sprpd_pkg::PC_W-1:0]          pc_reg, pc_next;
    logic [1:0]                          k_reg, k_next;
    logic signed [sprpd_pkg::POS_W:0]    gap_reg, gap_next;
    logic                                fin_reg, fin_next;

    // Output register.
    logic                                res_valid_reg, res_valid_next;
    sprpd_pkg::res_t                     res_reg, res_next;

    sprpd_pkg::ucode_t                   cw;
    sprpd_pkg::dp_ctl_t                  dp_ctl;
    logic signed [sprpd_pkg::COEF_W-1:0] coef_sel;
    logic signed [sprpd_pkg::VOLT_W-1:0] volts;
    logic [sprpd_pkg::STEP_W-1:0]        step_eff;
    logic signed [sprpd_pkg::POS_W:0]    step_s;
    logic                                req_fire;
    logic                                out_free;

    assign req_stall = busy_reg;
    assign req_fire  = req_valid && !req_stall;
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;
    assign out_free  = !res_valid_reg || !res_stall;

    assign cw       = sprpd_pkg::ucode_rom(pc_reg);
    assign step_eff = (step_size_reg == '0) ? sprpd_pkg::STEP_W'(1) : step_size_reg;
    assign step_s   = $signed({2'b00, step_eff});
    assign coef_sel = dp_ctl.load ? coef_reg[4] : coef_reg[{1'b0, k_reg}];

    // Decode the control word into datapath strobes.
    always_comb
    begin
        dp_ctl = '0;
        if (busy_reg)
        begin
            unique case (cw.uop)
                sprpd_pkg::UOP_GAP:  dp_ctl.load     = 1'b1;
                sprpd_pkg::UOP_MULH: dp_ctl.mul_hi   = 1'b1;
                sprpd_pkg::UOP_MULL: dp_ctl.mul_lo   = 1'b1;
                sprpd_pkg::UOP_ACC:  dp_ctl.add_coef = 1'b1;
                default:             dp_ctl = '0;
            endcase
        end
    end

    sprpd_horner u_horner (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (dp_ctl),
        .x     (position_reg),
        .coef  (coef_sel),
        .volts (volts)
    );

    // Request acceptance, sequencer stepping and the output register.
    always_comb
    begin
        position_next  = position_reg;
        goal_next      = goal_reg;
        ramping_next   = ramping_reg;
        wait_next      = wait_reg;
        busy_next      = busy_reg;
        pc_next        = pc_reg;
        k_next         = k_reg;
        gap_next       = gap_reg;
        fin_next       = fin_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;

        if (req_fire)
        begin
            if (req_data.op == sprpd_pkg::OP_LOAD)
            begin
                goal_next    = req_data.target_value;
                ramping_next = 1'b1;
                busy_next    = 1'b1;
                pc_next      = sprpd_pkg::PC_START;
            end
            else if (ramping_reg)
            begin
                if (wait_reg != '0)
                begin
                    wait_next = wait_reg - sprpd_pkg::DELAY_W'(1);
                end
                else
                begin
                    busy_next = 1'b1;
                    pc_next   = sprpd_pkg::PC_START;
                end
            end
        end

        if (busy_reg)
        begin
            pc_next = pc_reg + sprpd_pkg::PC_W'(1);
            unique case (cw.uop)
                sprpd_pkg::UOP_GAP:
                begin
                    gap_next = (sprpd_pkg::POS_W+1)'(goal_reg)
                             - (sprpd_pkg::POS_W+1)'(position_reg);
                    k_next   = 2'd3;
                end
                sprpd_pkg::UOP_MOVE:
                begin
                    // Move one step toward the goal, or snap when within a step.
                    fin_next  = 1'b0;
                    wait_next = step_delay_reg;
                    if (gap_reg > step_s)
                    begin
                        position_next = position_reg + $signed({1'b0, step_eff});
                    end
                    else if (gap_reg < -step_s)
                    begin
                        position_next = position_reg - $signed({1'b0, step_eff});
                    end
                    else
                    begin
                        position_next = goal_reg;
                        ramping_next  = 1'b0;
                        fin_next      = 1'b1;
                    end
                end
                sprpd_pkg::UOP_ACC:
                begin
                    k_next = k_reg - 2'd1;
                    if (cw.jump && (k_reg != 2'd0))
                    begin
                        pc_next = cw.target;
                    end
                end
                sprpd_pkg::UOP_FIN:
                begin
                    // Hand the result over once the output register is free.
                    pc_next = pc_reg;
                    if (out_free)
                    begin
                        res_next.drive_volts  = volts;
                        res_next.position_now = position_reg;
                        res_next.final_step   = fin_reg;
                        res_valid_next        = 1'b1;
                        busy_next             = 1'b0;
                    end
                end
                default:
                begin
                    pc_next = pc_reg + sprpd_pkg::PC_W'(1);
                end
            endcase
        end
    end

    // Control state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg  <= sprpd_pkg::STEP_SIZE_RST;
            step_delay_reg <= sprpd_pkg::STEP_DELAY_RST;
            coef_reg[0]    <= sprpd_pkg::COEF0_RST;
            coef_reg[1]    <= sprpd_pkg::COEF1_RST;
            coef_reg[2]    <= sprpd_pkg::COEF2_RST;
            coef_reg[3]    <= sprpd_pkg::COEF3_RST;
            coef_reg[4]    <= sprpd_pkg::COEF4_RST;
            position_reg   <= '0;
            goal_reg       <= '0;
            ramping_reg    <= 1'b0;
            wait_reg       <= '0;
            busy_reg       <= 1'b0;
            pc_reg         <= sprpd_pkg::PC_START;
            k_reg          <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            position_reg  <= position_next;
            goal_reg      <= goal_next;
            ramping_reg   <= ramping_next;
            wait_reg      <= wait_next;
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            k_reg         <= k_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    sprpd_pkg::CFG_STEP_SIZE:
                        step_size_reg <= cfg_data[sprpd_pkg::STEP_W-1:0];
                    sprpd_pkg::CFG_STEP_DELAY:
                        step_delay_reg <= cfg_data[sprpd_pkg::DELAY_W-1:0];
                    sprpd_pkg::CFG_COEF_ZERO:  coef_reg[0] <= $signed(cfg_data);
                    sprpd_pkg::CFG_COEF_ONE:   coef_reg[1] <= $signed(cfg_data);
                    sprpd_pkg::CFG_COEF_TWO:   coef_reg[2] <= $signed(cfg_data);
                    sprpd_pkg::CFG_COEF_THREE: coef_reg[3] <= $signed(cfg_data);
                    sprpd_pkg::CFG_COEF_FOUR:  coef_reg[4] <= $signed(cfg_data);
                    default:
                    begin
                        step_size_reg <= step_size_reg;
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        gap_reg <= gap_next;
        fin_reg <= fin_next;
        res_reg <= res_next;
    end

endmodule

@@ rtl/sprpd_checker.sv @@
// Port-level checks for the setpoint ramp drive, bound to the top level.
module sprpd_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    input  logic                                  req_stall,
    input  sprpd_pkg::req_t                       req_data,
    input  logic                                  res_valid,
    input  logic                                  res_stall,
    input  sprpd_pkg::res_t                       res_data,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result dropped while stalled");

    // A load request always starts a step sequence, so the block goes busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (req_data.op == sprpd_pkg::OP_LOAD) |=> req_stall)
        else $error("load request did not start a step");

    // The drive voltage never leaves the saturation range.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_data.drive_volts <= sprpd_pkg::VOLT_W'(sprpd_pkg::VOLT_MAX))
                   && (res_data.drive_volts >= -sprpd_pkg::VOLT_W'(sprpd_pkg::VOLT_MAX)))
        else $error("drive voltage outside +/-10 V");

    // A new result only appears after a step sequence ran.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(req_stall))
        else $error("result without a step sequence");

    // A configuration write is never held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write held off");

endmodule

bind setpoint_ramp_poly_drive sprpd_checker u_sprpd_checker (.*);
